// ----- rtl/knng_pkg.sv -----
package knng_pkg;

    localparam int MAX_POINTS     = 256;
    localparam int NEIGHBOR_COUNT = 3;
    localparam int COORD_BITS     = 16;

    localparam int IDX_BITS  = $clog2(MAX_POINTS);
    localparam int CNT_BITS  = $clog2(MAX_POINTS + 1);
    localparam int PT_BITS   = 3 * COORD_BITS;
    localparam int SQ_BITS   = 2 * COORD_BITS;
    localparam int SUM_BITS  = 2 * COORD_BITS + 2;
    localparam int DIST_BITS = (SUM_BITS > 64) ? 64 : SUM_BITS;

    localparam int OP_BITS = 2;
    localparam int ST_BITS = 2;
    localparam int IN_BITS = 16;
    localparam int QI_BITS = 8;
    localparam int NB_BITS = 8;
    localparam int PC_BITS = 9;

    localparam logic [OP_BITS-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_BITS-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_BITS-1:0] OP_QUERY  = 2'd2;

    localparam logic [ST_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [ST_BITS-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_BITS-1:0] ST_RANGE = 2'd2;
    localparam logic [ST_BITS-1:0] ST_FEW   = 2'd3;

    typedef struct packed {
        logic                valid;
        logic [IDX_BITS-1:0] idx;
    } t_tag;

    typedef struct packed {
        logic                 valid;
        logic [IDX_BITS-1:0]  idx;
        logic [DIST_BITS-1:0] dist_sq;
    } t_cand;

endpackage

// ----- rtl/knng_store.sv -----
module knng_store (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [knng_pkg::IDX_BITS-1:0] i_wr_addr,
    input  logic [knng_pkg::PT_BITS-1:0]  i_wr_data,
    input  logic                          i_rd_en,
    input  logic [knng_pkg::IDX_BITS-1:0] i_rd_addr,
    output logic [knng_pkg::PT_BITS-1:0]  o_rd_data
);

    logic [knng_pkg::PT_BITS-1:0] r_mem [knng_pkg::MAX_POINTS];
    logic [knng_pkg::PT_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/knng_dist.sv -----
module knng_dist (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load_query,
    input  logic [knng_pkg::PT_BITS-1:0] i_point,
    input  knng_pkg::t_tag               i_tag,
    output knng_pkg::t_cand              o_cand,
    output logic                         o_busy
);

    localparam int CB = knng_pkg::COORD_BITS;
    localparam int SQ = knng_pkg::SQ_BITS;
    localparam int SB = knng_pkg::SUM_BITS;
    localparam int DB = knng_pkg::DIST_BITS;

    logic [knng_pkg::PT_BITS-1:0] r_qry;
    logic signed [CB:0]           diff [3];
    logic [CB-1:0]                mag  [3];
    logic [CB-1:0]                r_mag [3];
    logic [SQ-1:0]                r_sq  [3];
    logic [SB-1:0]                sum_full;
    logic [DB-1:0]                dist_sat;
    logic [DB-1:0]                r_dist;
    knng_pkg::t_tag               r_tag1;
    knng_pkg::t_tag               r_tag2;
    knng_pkg::t_tag               r_tag3;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            diff[a] = (CB+1)'($signed(i_point[a*CB +: CB]))
                    - (CB+1)'($signed(r_qry[a*CB +: CB]));
            mag[a]  = diff[a][CB] ? CB'(-diff[a]) : CB'(diff[a]);
        end
    end

    assign sum_full = SB'(r_sq[0]) + SB'(r_sq[1]) + SB'(r_sq[2]);

    generate
        if (SB > DB) begin : g_sat
            assign dist_sat = (|sum_full[SB-1:DB]) ? '1 : sum_full[DB-1:0];
        end else begin : g_nosat
            assign dist_sat = sum_full;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1.valid <= 1'b0;
            r_tag2.valid <= 1'b0;
            r_tag3.valid <= 1'b0;
        end else begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
            r_tag3 <= r_tag2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load_query) begin
            r_qry <= i_point;
        end
        for (int a = 0; a < 3; a++) begin
            r_mag[a] <= mag[a];
            r_sq[a]  <= SQ'(r_mag[a]) * SQ'(r_mag[a]);
        end
        r_dist <= dist_sat;
    end

    assign o_cand.valid   = r_tag3.valid;
    assign o_cand.idx     = r_tag3.idx;
    assign o_cand.dist_sq = r_dist;
    assign o_busy         = i_tag.valid | r_tag1.valid | r_tag2.valid | r_tag3.valid;

endmodule

// ----- rtl/knng_rank.sv -----
module knng_rank (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_clear,
    input  knng_pkg::t_cand i_cand,
    output logic [knng_pkg::NEIGHBOR_COUNT-1:0][knng_pkg::IDX_BITS-1:0] o_idx
);

    localparam int N = knng_pkg::NEIGHBOR_COUNT;

    logic [N-1:0]                                   r_valid;
    logic [N-1:0][knng_pkg::DIST_BITS-1:0]          r_dist;
    logic [N-1:0][knng_pkg::IDX_BITS-1:0]           r_idx;
    logic [N-1:0]                                   lt;
    logic [N-1:0]                                   take_new;
    logic [N-1:0]                                   take_prev;

    // A strict compare keeps the earlier, lower index ahead on equal distances.
    always_comb begin
        for (int k = 0; k < N; k++) begin
            lt[k] = !r_valid[k] || (i_cand.dist_sq < r_dist[k]);
        end
        take_new[0]  = lt[0];
        take_prev[0] = 1'b0;
        for (int k = 1; k < N; k++) begin
            take_new[k]  = lt[k] && !lt[k-1];
            take_prev[k] = lt[k] && lt[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_clear) begin
            r_valid <= '0;
        end else if (i_cand.valid) begin
            r_valid[0] <= r_valid[0] | take_new[0];
            for (int k = 1; k < N; k++) begin
                if (take_new[k]) begin
                    r_valid[k] <= 1'b1;
                end else if (take_prev[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cand.valid) begin
            if (take_new[0]) begin
                r_dist[0] <= i_cand.dist_sq;
                r_idx[0]  <= i_cand.idx;
            end
            for (int k = 1; k < N; k++) begin
                if (take_new[k]) begin
                    r_dist[k] <= i_cand.dist_sq;
                    r_idx[k]  <= i_cand.idx;
                end else if (take_prev[k]) begin
                    r_dist[k] <= r_dist[k-1];
                    r_idx[k]  <= r_idx[k-1];
                end
            end
        end
    end

    assign o_idx = r_idx;

endmodule

// ----- rtl/k_nearest_neighbor_graph_core.sv -----
// Channel   Direction  Handshake                 Payload
// request   in         i_in_valid / o_in_ready   i_opcode, i_coord_x/y/z, i_query_index
// result    out        o_out_valid / i_out_ready o_status, o_neighbor_*, o_point_count
//
// Clear, append and failed queries give their result one cycle after acceptance.
// A query scans all point_count stored points: the single store read port visits one
// stored point per cycle, followed by the distance pipeline and ranking stage.
// Reset zeroes the point count; store contents are not cleared.
// A new request is taken only when idle and the result register is free or
// being emptied in the same cycle.
module k_nearest_neighbor_graph_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [knng_pkg::OP_BITS-1:0]        i_opcode,
    input  logic signed [knng_pkg::IN_BITS-1:0] i_coord_x,
    input  logic signed [knng_pkg::IN_BITS-1:0] i_coord_y,
    input  logic signed [knng_pkg::IN_BITS-1:0] i_coord_z,
    input  logic [knng_pkg::QI_BITS-1:0]        i_query_index,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [knng_pkg::ST_BITS-1:0]        o_status,
    output logic [knng_pkg::NB_BITS-1:0]        o_neighbor_first,
    output logic [knng_pkg::NB_BITS-1:0]        o_neighbor_second,
    output logic [knng_pkg::NB_BITS-1:0]        o_neighbor_third,
    output logic [knng_pkg::PC_BITS-1:0]        o_point_count
);

    localparam int CB  = knng_pkg::COORD_BITS;
    localparam int IB  = knng_pkg::IDX_BITS;
    localparam int CNB = knng_pkg::CNT_BITS;
    localparam int NB  = knng_pkg::NB_BITS;
    localparam int PCB = knng_pkg::PC_BITS;
    localparam int QCB = knng_pkg::CNT_BITS + knng_pkg::QI_BITS;
    localparam int N   = knng_pkg::NEIGHBOR_COUNT;

    typedef enum logic [1:0] {
        S_IDLE,
        S_QLOAD,
        S_SCAN,
        S_DRAIN
    } t_state;

    t_state                        r_state;
    logic [CNB-1:0]                r_count;
    logic [CNB-1:0]                n_count;
    logic [IB-1:0]                 r_scan_idx;
    knng_pkg::t_tag                r_rd_tag;
    knng_pkg::t_tag                n_rd_tag;
    logic                          r_out_valid;
    logic [knng_pkg::ST_BITS-1:0]  r_status;
    logic [knng_pkg::ST_BITS-1:0]  n_status;
    logic [NB-1:0]                 r_nb [3];
    logic [PCB-1:0]                r_point_count;

    logic                          accept;
    logic                          qidx_ok;
    logic                          few;
    logic                          full;
    logic                          start_query;
    logic                          wr_en;
    logic                          rd_en;
    logic [IB-1:0]                 rd_addr;
    logic [knng_pkg::PT_BITS-1:0]  wr_data;
    logic [knng_pkg::PT_BITS-1:0]  rd_data;
    knng_pkg::t_cand               cand;
    logic                          busy;
    logic [N-1:0][IB-1:0]          rank_idx;
    logic [NB-1:0]                 nb_sel [3];

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept      = i_in_valid && o_in_ready;
    assign qidx_ok     = QCB'(i_query_index) < QCB'(r_count);
    assign few         = r_count < CNB'(N);
    assign full        = r_count == CNB'(knng_pkg::MAX_POINTS);
    assign start_query = accept && (i_opcode == knng_pkg::OP_QUERY) && qidx_ok && !few;

    assign wr_en   = accept && (i_opcode == knng_pkg::OP_APPEND) && !full;
    assign wr_data = {CB'(i_coord_z), CB'(i_coord_y), CB'(i_coord_x)};

    always_comb begin
        n_rd_tag.valid = (r_state == S_SCAN);
        n_rd_tag.idx   = r_scan_idx;
        rd_en          = start_query || (r_state == S_SCAN);
        rd_addr        = (r_state == S_SCAN) ? r_scan_idx : IB'(i_query_index);
    end

    always_comb begin
        n_count  = r_count;
        n_status = knng_pkg::ST_OK;
        case (i_opcode)
            knng_pkg::OP_CLEAR: begin
                n_count = '0;
            end
            knng_pkg::OP_APPEND: begin
                if (full) begin
                    n_status = knng_pkg::ST_FULL;
                end else begin
                    n_count = r_count + CNB'(1);
                end
            end
            knng_pkg::OP_QUERY: begin
                if (!qidx_ok) begin
                    n_status = knng_pkg::ST_RANGE;
                end else if (few) begin
                    n_status = knng_pkg::ST_FEW;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            nb_sel[k] = '0;
            if (k < N) begin
                nb_sel[k] = NB'(rank_idx[k]);
            end
        end
    end

    knng_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (IB'(r_count)),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    knng_dist u_dist (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_query (r_state == S_QLOAD),
        .i_point      (rd_data),
        .i_tag        (r_rd_tag),
        .o_cand       (cand),
        .o_busy       (busy)
    );

    knng_rank u_rank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (start_query),
        .i_cand  (cand),
        .o_idx   (rank_idx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_count        <= '0;
            r_out_valid    <= 1'b0;
            r_rd_tag.valid <= 1'b0;
        end else begin
            r_rd_tag <= n_rd_tag;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_count       <= n_count;
                        r_status      <= n_status;
                        for (int k = 0; k < 3; k++) begin
                            r_nb[k] <= '0;
                        end
                        r_point_count <= PCB'(n_count);
                        r_out_valid   <= !start_query;
                        if (start_query) begin
                            r_state <= S_QLOAD;
                        end
                    end else if (r_out_valid && i_out_ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_QLOAD: begin
                    r_scan_idx <= '0;
                    r_state    <= S_SCAN;
                end
                S_SCAN: begin
                    r_scan_idx <= r_scan_idx + IB'(1);
                    if (r_scan_idx == IB'(r_count - CNB'(1))) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!busy) begin
                        r_status      <= knng_pkg::ST_OK;
                        for (int k = 0; k < 3; k++) begin
                            r_nb[k] <= nb_sel[k];
                        end
                        r_point_count <= PCB'(r_count);
                        r_out_valid   <= 1'b1;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_neighbor_first  = r_nb[0];
    assign o_neighbor_second = r_nb[1];
    assign o_neighbor_third  = r_nb[2];
    assign o_point_count     = r_point_count;

endmodule
